[design/iep_pkg.sv]
// Package: shared types and constants for the init event TLV parser.
`default_nettype none
package iep_pkg;

    // Default maximum packet size in bytes
    localparam int MAX_BYTES_DEF = 256;

    // Header and event constants
    localparam logic [7:0] HDR_NIBBLE_MASK = 8'h0f;
    localparam logic [7:0] HDR_NIBBLE_VAL  = 8'h05;
    localparam logic [7:0] PKT_TYPE_EVENT  = 8'h33;
    localparam logic [7:0] HDR_BYTES       = 8'd12;
    localparam logic [7:0] EVT_TAG_INIT    = 8'h22;

    // Entry tags
    localparam logic [7:0] TAG_CAPS    = 8'h11;
    localparam logic [7:0] TAG_CHIP_ID = 8'h12;
    localparam logic [7:0] TAG_RX_QUE  = 8'h14;
    localparam logic [7:0] TAG_TX_QUE  = 8'h15;
    localparam logic [7:0] TAG_FW_VER  = 8'h17;

    // Device acceptance
    localparam logic [7:0] CHIP_ID_OK  = 8'h0d;
    localparam logic [7:0] CAP_REQ_BIT = 8'h01;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_PROTO = 2'd1,
        ST_SIZE  = 2'd2,
        ST_UNSUP = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        PH_TAG = 2'd0,
        PH_LEN = 2'd1,
        PH_VAL = 2'd2
    } t_phase;

    // Control from the header stage to the entry walker
    typedef struct packed {
        logic step;   // byte consumed this cycle
        logic load;   // event length byte
        logic walk;   // byte inside the entry region
        logic clear;  // final byte of the packet
    } t_walk_ctl;

    // Walker results after the current byte
    typedef struct packed {
        logic        err;
        logic [7:0]  caps;
        logic [7:0]  chip_id;
        logic [7:0]  rx_que;
        logic [7:0]  tx_que;
        logic [31:0] fw_ver;
    } t_walk_res;

endpackage
`default_nettype wire

[design/iep_if.sv]
// Interfaces: byte input channel and result output channel.
`default_nettype none
interface iep_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface iep_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  capabilities;
    logic [7:0]  device_id;
    logic [7:0]  rx_queue_depth;
    logic [7:0]  tx_queue_depth;
    logic [31:0] fw_version;

    modport source (output valid, output status, output capabilities, output device_id,
                    output rx_queue_depth, output tx_queue_depth,
                    output fw_version, input ready);
    modport sink   (input valid, input status, input capabilities, input device_id,
                    input rx_queue_depth, input tx_queue_depth,
                    input fw_version, output ready);
endinterface
`default_nettype wire

[design/iep_walk.sv]
// Entry walker: steps through the TLV entries of the init event and captures values.
`default_nettype none
module iep_walk (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire iep_pkg::t_walk_ctl i_ctl,
    input  wire logic [7:0]        i_data,
    output iep_pkg::t_walk_res     o_res
);
    import iep_pkg::*;

    t_phase      r_phase,  n_phase;
    logic [7:0]  r_region, n_region;
    logic [7:0]  r_tag,    n_tag;
    logic [7:0]  r_len,    n_len;
    logic [7:0]  r_pos,    n_pos;
    logic        r_err,    n_err;
    logic [7:0]  r_caps,   n_caps;
    logic [7:0]  r_chip,   n_chip;
    logic [7:0]  r_rxq,    n_rxq;
    logic [7:0]  r_txq,    n_txq;
    logic [31:0] r_acc,    n_acc;
    logic [31:0] r_ver,    n_ver;
    logic [31:0] acc_new;

    // Merge the value byte into the accumulator, low byte first
    always_comb begin
        acc_new = r_acc;
        if (r_pos < 8'd4) begin
            case (r_pos[1:0])
                2'd0:    acc_new[7:0]   = r_acc[7:0]   | i_data;
                2'd1:    acc_new[15:8]  = r_acc[15:8]  | i_data;
                2'd2:    acc_new[23:16] = r_acc[23:16] | i_data;
                default: acc_new[31:24] = r_acc[31:24] | i_data;
            endcase
        end
    end

    // Advance the walk by one byte
    always_comb begin
        n_phase  = r_phase;
        n_region = r_region;
        n_tag    = r_tag;
        n_len    = r_len;
        n_pos    = r_pos;
        n_err    = r_err;
        n_caps   = r_caps;
        n_chip   = r_chip;
        n_rxq    = r_rxq;
        n_txq    = r_txq;
        n_acc    = r_acc;
        n_ver    = r_ver;
        if (i_ctl.load) begin
            n_region = i_data;
            n_phase  = PH_TAG;
        end else if (i_ctl.walk && !r_err) begin
            case (r_phase)
                PH_TAG: begin
                    if (r_region != 8'd0) begin
                        if (r_region < 8'd2) begin
                            n_err = 1'b1;
                        end else begin
                            n_tag    = i_data;
                            n_region = r_region - 8'd2;
                            n_phase  = PH_LEN;
                        end
                    end
                end
                PH_LEN: begin
                    n_len = i_data;
                    if (i_data > r_region) begin
                        n_err = 1'b1;
                    end else begin
                        n_region = r_region - i_data;
                        n_pos    = 8'd0;
                        n_acc    = 32'd0;
                        n_phase  = (i_data == 8'd0) ? PH_TAG : PH_VAL;
                    end
                end
                PH_VAL: begin
                    n_acc = acc_new;
                    n_pos = r_pos + 8'd1;
                    if (n_pos == r_len) begin
                        n_phase = PH_TAG;
                        // Commit the finished entry
                        if (r_len == 8'd1) begin
                            if (r_tag == TAG_CAPS)         n_caps = acc_new[7:0];
                            else if (r_tag == TAG_CHIP_ID) n_chip = acc_new[7:0];
                            else if (r_tag == TAG_RX_QUE)  n_rxq  = acc_new[7:0];
                            else if (r_tag == TAG_TX_QUE)  n_txq  = acc_new[7:0];
                        end else if (r_len == 8'd4 && r_tag == TAG_FW_VER) begin
                            n_ver = acc_new;
                        end
                    end
                end
                default: begin
                    n_phase = PH_TAG;
                end
            endcase
        end
    end

    // Report the state as it stands after this byte
    assign o_res.err     = n_err;
    assign o_res.caps    = n_caps;
    assign o_res.chip_id = n_chip;
    assign o_res.rx_que  = n_rxq;
    assign o_res.tx_que  = n_txq;
    assign o_res.fw_ver  = n_ver;

    // Hold walk state; clear at the end of each packet
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_ctl.step && i_ctl.clear)) begin
            r_phase  <= PH_TAG;
            r_region <= 8'd0;
            r_tag    <= 8'd0;
            r_len    <= 8'd0;
            r_pos    <= 8'd0;
            r_err    <= 1'b0;
            r_caps   <= 8'd0;
            r_chip   <= 8'd0;
            r_rxq    <= 8'd0;
            r_txq    <= 8'd0;
            r_acc    <= 32'd0;
            r_ver    <= 32'd0;
        end else if (i_ctl.step) begin
            r_phase  <= n_phase;
            r_region <= n_region;
            r_tag    <= n_tag;
            r_len    <= n_len;
            r_pos    <= n_pos;
            r_err    <= n_err;
            r_caps   <= n_caps;
            r_chip   <= n_chip;
            r_rxq    <= n_rxq;
            r_txq    <= n_txq;
            r_acc    <= n_acc;
            r_ver    <= n_ver;
        end
    end

endmodule
`default_nettype wire

[design/init_event_tlv_parser.sv]
// Top level: init event TLV parser with input register, header checks and result register.
//
// Usage: feed packet bytes on i_byte, one per transfer, with last_byte set on the
// final byte. One result transfer leaves on o_res for every final byte; no other
// byte produces a result. The result carries the status (ok, protocol error, size
// error, unsupported device) and the captured capability, chip id, queue sizes and
// firmware version; the values are zero on protocol or size errors.
// Throughput: one byte per cycle while no final byte waits behind a held result.
// Every byte passes an input register before it is processed; the result sits in
// an output register. The final byte's transfer fills the input register, and
// consuming it there loads the result register.
// Stall: a held result blocks only a following final byte in the input register;
// other bytes keep flowing, so i_byte.ready drops only when a second result waits.
// Reset: i_rst_n, synchronous and active low, empties both registers and returns
// the parser to the start of a packet. The parser also returns there after each
// final byte. Packets longer than MAX_PACKET_BYTES end with a size error.
`default_nettype none
module init_event_tlv_parser #(
    parameter int MAX_PACKET_BYTES = iep_pkg::MAX_BYTES_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    iep_byte_if.sink       i_byte,
    iep_res_if.source      o_res
);
    import iep_pkg::*;

    localparam int CW = $clog2(MAX_PACKET_BYTES + 2);
    localparam logic [CW-1:0] CNT_SAT = CW'(MAX_PACKET_BYTES + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_PACKET_BYTES);

    // Input register
    logic        r_in_valid;
    logic [7:0]  r_in_data;
    logic        r_in_last;
    logic        fire;

    // Header state
    logic [CW-1:0] r_count,   n_count;
    logic          r_hdr_bad, n_hdr_bad;
    logic [15:0]   r_plen,    n_plen;
    logic [15:0]   r_pstart,  n_pstart;
    logic          r_tag_bad, n_tag_bad;
    logic [7:0]    r_elen,    n_elen;

    // Result register
    logic        r_out_valid;
    t_status     r_status;
    logic [7:0]  r_caps;
    logic [7:0]  r_chip;
    logic [7:0]  r_rxq;
    logic [7:0]  r_txq;
    logic [31:0] r_ver;

    t_walk_ctl   walk_ctl;
    t_walk_res   walk_res;
    t_status     status;
    logic [16:0] len_ext;

    // Consume the held byte unless it would overwrite a waiting result
    assign fire = r_in_valid && (!r_in_last || !r_out_valid || o_res.ready);
    assign i_byte.ready = !r_in_valid || fire;

    // Capture each input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_byte.valid && i_byte.ready) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
        if (i_byte.valid && i_byte.ready) begin
            r_in_data <= i_byte.data_byte;
            r_in_last <= i_byte.last_byte;
        end
    end

    // Decode header fields by byte position
    always_comb begin
        n_count   = (r_count != CNT_SAT) ? r_count + CW'(1) : r_count;
        n_hdr_bad = r_hdr_bad;
        n_plen    = r_plen;
        n_pstart  = r_pstart;
        n_tag_bad = r_tag_bad;
        n_elen    = r_elen;
        walk_ctl.step  = fire;
        walk_ctl.load  = 1'b0;
        walk_ctl.walk  = 1'b0;
        walk_ctl.clear = r_in_last;
        case (r_count)
            CW'(0):  n_hdr_bad = r_hdr_bad
                         || ((r_in_data & HDR_NIBBLE_MASK) != HDR_NIBBLE_VAL);
            CW'(2):  n_plen[7:0]    = r_in_data;
            CW'(3):  n_plen[15:8]   = r_in_data;
            CW'(4):  n_pstart[7:0]  = r_in_data;
            CW'(5):  n_pstart[15:8] = r_in_data;
            CW'(11): n_hdr_bad = r_hdr_bad || (r_in_data != PKT_TYPE_EVENT);
            CW'(12): n_tag_bad = (r_in_data != EVT_TAG_INIT);
            CW'(13): begin
                n_elen        = r_in_data;
                walk_ctl.load = 1'b1;
            end
            default: walk_ctl.walk = (r_count >= CW'(14));
        endcase
    end

    iep_walk u_walk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (walk_ctl),
        .i_data  (r_in_data),
        .o_res   (walk_res)
    );

    // Resolve the packet status in priority order
    assign len_ext = 17'(n_count);
    always_comb begin
        if (n_count > CNT_MAX) begin
            status = ST_SIZE;
        end else if (n_count < CW'(HDR_BYTES) || n_hdr_bad) begin
            status = ST_PROTO;
        end else if (n_pstart != 16'(HDR_BYTES)
                     || 17'(n_plen) > len_ext - 17'(HDR_BYTES)
                     || n_plen < 16'd2) begin
            status = ST_SIZE;
        end else if (n_tag_bad) begin
            status = ST_PROTO;
        end else if (17'(n_elen) + 17'd2 > 17'(n_plen)) begin
            status = ST_SIZE;
        end else if (walk_res.err) begin
            status = ST_PROTO;
        end else if (walk_res.chip_id != CHIP_ID_OK
                     || (walk_res.caps & CAP_REQ_BIT) == 8'd0) begin
            status = ST_UNSUP;
        end else begin
            status = ST_OK;
        end
    end

    // Hold header state; restart at the final byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (fire && r_in_last)) begin
            r_count   <= '0;
            r_hdr_bad <= 1'b0;
            r_plen    <= 16'd0;
            r_pstart  <= 16'd0;
            r_tag_bad <= 1'b0;
            r_elen    <= 8'd0;
        end else if (fire) begin
            r_count   <= n_count;
            r_hdr_bad <= n_hdr_bad;
            r_plen    <= n_plen;
            r_pstart  <= n_pstart;
            r_tag_bad <= n_tag_bad;
            r_elen    <= n_elen;
        end
    end

    // Load the result on the final byte, drop it once transferred
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
        if (fire && r_in_last) begin
            r_status <= status;
            if (status == ST_OK || status == ST_UNSUP) begin
                r_caps <= walk_res.caps;
                r_chip <= walk_res.chip_id;
                r_rxq  <= walk_res.rx_que;
                r_txq  <= walk_res.tx_que;
                r_ver  <= walk_res.fw_ver;
            end else begin
                r_caps <= 8'd0;
                r_chip <= 8'd0;
                r_rxq  <= 8'd0;
                r_txq  <= 8'd0;
                r_ver  <= 32'd0;
            end
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.status         = r_status;
    assign o_res.capabilities   = r_caps;
    assign o_res.device_id      = r_chip;
    assign o_res.rx_queue_depth = r_rxq;
    assign o_res.tx_queue_depth = r_txq;
    assign o_res.fw_version     = r_ver;

    // Byte counter saturates one past the size limit
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_SAT)
        else $error("byte counter past saturation");

    // A final byte restarts the count
    a_count_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_in_last |=> r_count == '0)
        else $error("byte counter not cleared after final byte");

    // An ok result always names the supported device
    a_ok_device: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_status == ST_OK |->
            r_chip == CHIP_ID_OK && (r_caps & CAP_REQ_BIT) != 8'd0)
        else $error("ok status with unsupported device values");

    // Error results carry zero values
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_status == ST_PROTO || r_status == ST_SIZE) |->
            r_caps == 8'd0 && r_chip == 8'd0 && r_rxq == 8'd0
            && r_txq == 8'd0 && r_ver == 32'd0)
        else $error("error result carries nonzero values");

    // A waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_res.ready |-> !(fire && r_in_last))
        else $error("result overwritten while stalled");

endmodule
`default_nettype wire
